// File: src/cpa3d_pkg.sv
`default_nettype none

package cpa3d_pkg;

   // default field geometry
   localparam int COORD_WIDTH = 32;
   localparam int FRAC_BITS   = 16;

   // result field widths
   localparam int TIME_WIDTH = 48;
   localparam int LEN_WIDTH  = 36;

   // number of vector fields on one request beat
   localparam int NUM_IN_FIELDS = 12;

   // response beat layout
   localparam int RSP_DATA_W = TIME_WIDTH + 2 * LEN_WIDTH;
   localparam int RSP_USER_W = 2;

   // response tuser bit positions
   localparam int USER_STILL_BIT = 0;
   localparam int USER_SAT_BIT   = 1;

endpackage

`default_nettype wire

// File: src/closest_approach_3d_unit.sv
// throughput: one beat per cycle; set by the fully pipelined divider (one quotient bit
// per stage, time and distance in parallel) and square root (one root bit per stage)
// a stalled response beat freezes the whole pipeline; nothing is dropped or repeated
// reset: synchronous, clears all stage valid bits; data registers are not reset
`default_nettype none

module closest_approach_3d_unit #(
   parameter int COORD_WIDTH = cpa3d_pkg::COORD_WIDTH,
   parameter int FRAC_BITS   = cpa3d_pkg::FRAC_BITS,
   localparam int REQ_DATA_W = ((cpa3d_pkg::NUM_IN_FIELDS * COORD_WIDTH + 7) / 8) * 8
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              req_tvalid,
   output logic                                   req_tready,
   // proj_pos_x, proj_pos_y, proj_pos_z, proj_vel_x, proj_vel_y, proj_vel_z,
   // tgt_pos_x, tgt_pos_y, tgt_pos_z, tgt_vel_x, tgt_vel_y, tgt_vel_z
   input  wire logic [REQ_DATA_W-1:0]             req_tdata,
   output logic                                   rsp_tvalid,
   input  wire logic                              rsp_tready,
   // approach_time, approach_distance, closing_speed
   output logic [cpa3d_pkg::RSP_DATA_W-1:0]       rsp_tdata,
   // no_relative_motion, saturated
   output logic [cpa3d_pkg::RSP_USER_W-1:0]       rsp_tuser
);

   localparam int W    = COORD_WIDTH;
   localparam int F    = FRAC_BITS;
   localparam int DW   = W + 1;
   localparam int MW   = 2 * DW;
   localparam int SW   = 2 * W + 2;
   localparam int PW   = 2 * W + 3;
   localparam int XW   = 2 * W + 1;
   localparam int XLO  = W + 1;
   localparam int XHI  = W;
   localparam int QW   = 2 * XW;
   localparam int CW   = QW + 2;
   localparam int TW   = cpa3d_pkg::TIME_WIDTH;
   localparam int LW   = cpa3d_pkg::LEN_WIDTH;
   localparam int QT   = TW;
   localparam int QD   = 2 * LW;
   localparam int TNW  = SW + F;
   localparam int TCW  = (TNW > SW + QT) ? TNW : SW + QT;
   localparam int DCW  = (CW > SW + QD) ? CW : SW + QD;
   localparam int SQ0  = (QD > SW) ? QD : SW;
   localparam int SQW  = SQ0 + (SQ0 % 2);
   localparam int RW   = SQW / 2;
   localparam int NSTG = 9 + QD + RW;

   localparam logic [TW-1:0] TMAXP = {1'b0, {(TW-1){1'b1}}};
   localparam logic [TW-1:0] TMINN = {1'b1, {(TW-1){1'b0}}};
   localparam logic [LW-1:0] LMAX  = {LW{1'b1}};

   // pipeline control
   logic              adv;
   logic [NSTG-1:0]   vld_ff;

   assign adv        = !vld_ff[NSTG-1] || rsp_tready;
   assign req_tready = adv;
   assign rsp_tvalid = vld_ff[NSTG-1];

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (adv) begin
         vld_ff <= {vld_ff[NSTG-2:0], req_tvalid};
      end
   end

   // stage 0: relative position and velocity
   logic signed [DW-1:0] dr_in [3];
   logic signed [DW-1:0] dv_in [3];
   logic signed [DW-1:0] dr_ff [3];
   logic signed [DW-1:0] dv_ff [3];

   always_comb begin
      for (int a = 0; a < 3; a++) begin
         dr_in[a] = $signed({req_tdata[a*W + W-1], req_tdata[a*W +: W]})
                  - $signed({req_tdata[(6+a)*W + W-1], req_tdata[(6+a)*W +: W]});
         dv_in[a] = $signed({req_tdata[(3+a)*W + W-1], req_tdata[(3+a)*W +: W]})
                  - $signed({req_tdata[(9+a)*W + W-1], req_tdata[(9+a)*W +: W]});
      end
   end

   // stage 1: all products of dr and dv
   logic signed [MW-1:0] vv_in [3], pp_in [3], dd_in [3], xa_in [3], xb_in [3];
   logic signed [MW-1:0] vv_ff [3], pp_ff [3], dd_ff [3], xa_ff [3], xb_ff [3];

   always_comb begin
      for (int a = 0; a < 3; a++) begin
         vv_in[a] = MW'(dv_ff[a]) * MW'(dv_ff[a]);
         pp_in[a] = MW'(dr_ff[a]) * MW'(dv_ff[a]);
         dd_in[a] = MW'(dr_ff[a]) * MW'(dr_ff[a]);
         xa_in[a] = MW'(dr_ff[(a+1)%3]) * MW'(dv_ff[(a+2)%3]);
         xb_in[a] = MW'(dr_ff[(a+2)%3]) * MW'(dv_ff[(a+1)%3]);
      end
   end

   // stage 2: dot products and cross product magnitudes
   logic        [SW-1:0] v2_in, d2_in, v2_ff, d2_ff;
   logic signed [PW-1:0] p2_in, p2_ff;
   logic signed [MW-1:0] cx [3];
   logic        [XW-1:0] xm_in [3], xm_ff [3];

   always_comb begin
      v2_in = SW'(vv_ff[0]) + SW'(vv_ff[1]) + SW'(vv_ff[2]);
      d2_in = SW'(dd_ff[0]) + SW'(dd_ff[1]) + SW'(dd_ff[2]);
      p2_in = PW'(pp_ff[0]) + PW'(pp_ff[1]) + PW'(pp_ff[2]);
      for (int a = 0; a < 3; a++) begin
         cx[a]    = xa_ff[a] - xb_ff[a];
         xm_in[a] = cx[a][MW-1] ? XW'(-cx[a]) : XW'(cx[a]);
      end
   end

   // stage 3: split squares of the cross terms into partial products
   logic [2*XHI-1:0]     hh_in [3], hh_ff [3];
   logic [XHI+XLO-1:0]   hl_in [3], hl_ff [3];
   logic [2*XLO-1:0]     ll_in [3], ll_ff [3];
   logic [SW-1:0]        v3_ff, d3_ff;
   logic signed [PW-1:0] p3_ff;

   always_comb begin
      for (int a = 0; a < 3; a++) begin
         hh_in[a] = (2*XHI)'(xm_ff[a][XW-1:XLO]) * (2*XHI)'(xm_ff[a][XW-1:XLO]);
         hl_in[a] = (XHI+XLO)'(xm_ff[a][XW-1:XLO]) * (XHI+XLO)'(xm_ff[a][XLO-1:0]);
         ll_in[a] = (2*XLO)'(xm_ff[a][XLO-1:0]) * (2*XLO)'(xm_ff[a][XLO-1:0]);
      end
   end

   // stage 4: recombine squares
   logic [QW-1:0]        sq_in [3], sq_ff [3];
   logic [SW-1:0]        v4_ff, d4_ff;
   logic signed [PW-1:0] p4_ff;

   always_comb begin
      for (int a = 0; a < 3; a++) begin
         sq_in[a] = (QW'(hh_ff[a]) << (2*XLO)) + (QW'(hl_ff[a]) << (XLO+1)) + QW'(ll_ff[a]);
      end
   end

   // stage 5: squared cross product norm
   logic [CW-1:0]        c5_in, c5_ff;
   logic [SW-1:0]        v5_ff, d5_ff;
   logic signed [PW-1:0] p5_ff;

   assign c5_in = CW'(sq_ff[0]) + CW'(sq_ff[1]) + CW'(sq_ff[2]);

   // stage 6: numerators, overflow checks, divider entry
   logic [TCW-1:0] trem_ff [QD+1], trem_in [QD+1];
   logic [QT-1:0]  tq_ff   [QD+1], tq_in   [QD+1];
   logic [DCW-1:0] drem_ff [QD+1], drem_in [QD+1];
   logic [QD-1:0]  dq_ff   [QD+1], dq_in   [QD+1];
   logic [SW-1:0]  vq_ff   [QD+1];
   logic [SW-1:0]  dq_d_ff [QD+1];
   logic           still_q_ff [QD+1], pneg_q_ff [QD+1];
   logic           tovf_q_ff  [QD+1], dovf_q_ff [QD+1];
   logic [SW-1:0]  pmag;
   logic           pneg6, still6, tovf6, dovf6;

   always_comb begin
      pneg6  = p5_ff[PW-1];
      pmag   = pneg6 ? SW'(-p5_ff) : SW'(p5_ff);
      still6 = (v5_ff == '0);
      trem_in[0] = TCW'(pmag) << F;
      tovf6  = trem_in[0] >= (TCW'(v5_ff) << QT);
      drem_in[0] = DCW'(c5_ff);
      dovf6  = drem_in[0] >= (DCW'(v5_ff) << QD);
      tq_in[0] = '0;
      dq_in[0] = '0;
      // one quotient bit per stage, time and distance side by side
      for (int k = 0; k < QD; k++) begin
         trem_in[k+1] = trem_ff[k];
         tq_in[k+1]   = tq_ff[k];
         drem_in[k+1] = drem_ff[k];
         dq_in[k+1]   = dq_ff[k];
         if (k < QT) begin
            if (trem_ff[k] >= (TCW'(vq_ff[k]) << (QT-1-k))) begin
               trem_in[k+1] = trem_ff[k] - (TCW'(vq_ff[k]) << (QT-1-k));
               tq_in[k+1][QT-1-k] = 1'b1;
            end
         end
         if (drem_ff[k] >= (DCW'(vq_ff[k]) << (QD-1-k))) begin
            drem_in[k+1] = drem_ff[k] - (DCW'(vq_ff[k]) << (QD-1-k));
            dq_in[k+1][QD-1-k] = 1'b1;
         end
      end
   end

   // square root entry: time result, root operands
   logic [SQW:0]   ra_rem_ff [RW+1], ra_rem_in [RW+1];
   logic [RW-1:0]  ra_ff     [RW+1], ra_in     [RW+1];
   logic [SQW:0]   rb_rem_ff [RW+1], rb_rem_in [RW+1];
   logic [RW-1:0]  rb_ff     [RW+1], rb_in     [RW+1];
   logic [TW-1:0]  tres_ff   [RW+1];
   logic           tsat_ff   [RW+1], still_r_ff [RW+1], dovf_r_ff [RW+1];
   logic [TW-1:0]  tres_in;
   logic           tsat_in;
   logic [SQW:0]   trial_a, trial_b;

   always_comb begin
      tres_in = '0;
      tsat_in = 1'b0;
      if (!still_q_ff[QD]) begin
         if (pneg_q_ff[QD]) begin
            if (tovf_q_ff[QD] || tq_ff[QD] > TMAXP) begin
               tres_in = TMAXP;
               tsat_in = 1'b1;
            end else begin
               tres_in = tq_ff[QD];
            end
         end else begin
            if (tovf_q_ff[QD] || tq_ff[QD] > TMINN) begin
               tres_in = TMINN;
               tsat_in = 1'b1;
            end else begin
               tres_in = TW'(-tq_ff[QD]);
            end
         end
      end
      ra_rem_in[0] = still_q_ff[QD] ? (SQW+1)'(dq_d_ff[QD]) : (SQW+1)'(dq_ff[QD]);
      rb_rem_in[0] = (SQW+1)'(vq_ff[QD]);
      ra_in[0] = '0;
      rb_in[0] = '0;
      trial_a  = '0;
      trial_b  = '0;
      // one root bit per stage for distance and speed
      for (int j = 0; j < RW; j++) begin
         ra_rem_in[j+1] = ra_rem_ff[j];
         ra_in[j+1]     = ra_ff[j];
         rb_rem_in[j+1] = rb_rem_ff[j];
         rb_in[j+1]     = rb_ff[j];
         trial_a = ((SQW+1)'(ra_ff[j]) << (RW-j)) | ((SQW+1)'(1) << (2*(RW-1-j)));
         trial_b = ((SQW+1)'(rb_ff[j]) << (RW-j)) | ((SQW+1)'(1) << (2*(RW-1-j)));
         if (ra_rem_ff[j] >= trial_a) begin
            ra_rem_in[j+1] = ra_rem_ff[j] - trial_a;
            ra_in[j+1][RW-1-j] = 1'b1;
         end
         if (rb_rem_ff[j] >= trial_b) begin
            rb_rem_in[j+1] = rb_rem_ff[j] - trial_b;
            rb_in[j+1][RW-1-j] = 1'b1;
         end
      end
   end

   // output stage: length saturation and flags
   logic [TW-1:0] time_ff;
   logic [LW-1:0] dist_ff, speed_ff, dist_in, speed_in;
   logic          still_ff, sat_ff, dsat, ssat;

   always_comb begin
      dsat = dovf_r_ff[RW] || (ra_ff[RW] > RW'(LMAX));
      ssat = rb_ff[RW] > RW'(LMAX);
      dist_in  = dsat ? LMAX : LW'(ra_ff[RW]);
      speed_in = ssat ? LMAX : LW'(rb_ff[RW]);
   end

   // data registers, all held while the output beat waits
   always_ff @(posedge clock) begin
      if (adv) begin
         dr_ff <= dr_in;
         dv_ff <= dv_in;
         vv_ff <= vv_in;
         pp_ff <= pp_in;
         dd_ff <= dd_in;
         xa_ff <= xa_in;
         xb_ff <= xb_in;
         v2_ff <= v2_in;
         d2_ff <= d2_in;
         p2_ff <= p2_in;
         xm_ff <= xm_in;
         hh_ff <= hh_in;
         hl_ff <= hl_in;
         ll_ff <= ll_in;
         v3_ff <= v2_ff;
         d3_ff <= d2_ff;
         p3_ff <= p2_ff;
         sq_ff <= sq_in;
         v4_ff <= v3_ff;
         d4_ff <= d3_ff;
         p4_ff <= p3_ff;
         c5_ff <= c5_in;
         v5_ff <= v4_ff;
         d5_ff <= d4_ff;
         p5_ff <= p4_ff;
         trem_ff[0]    <= trem_in[0];
         tq_ff[0]      <= tq_in[0];
         drem_ff[0]    <= drem_in[0];
         dq_ff[0]      <= dq_in[0];
         vq_ff[0]      <= v5_ff;
         dq_d_ff[0]    <= d5_ff;
         still_q_ff[0] <= still6;
         pneg_q_ff[0]  <= pneg6;
         tovf_q_ff[0]  <= tovf6;
         dovf_q_ff[0]  <= dovf6;
         for (int k = 0; k < QD; k++) begin
            trem_ff[k+1]    <= trem_in[k+1];
            tq_ff[k+1]      <= tq_in[k+1];
            drem_ff[k+1]    <= drem_in[k+1];
            dq_ff[k+1]      <= dq_in[k+1];
            vq_ff[k+1]      <= vq_ff[k];
            dq_d_ff[k+1]    <= dq_d_ff[k];
            still_q_ff[k+1] <= still_q_ff[k];
            pneg_q_ff[k+1]  <= pneg_q_ff[k];
            tovf_q_ff[k+1]  <= tovf_q_ff[k];
            dovf_q_ff[k+1]  <= dovf_q_ff[k];
         end
         ra_rem_ff[0]  <= ra_rem_in[0];
         ra_ff[0]      <= ra_in[0];
         rb_rem_ff[0]  <= rb_rem_in[0];
         rb_ff[0]      <= rb_in[0];
         tres_ff[0]    <= tres_in;
         tsat_ff[0]    <= tsat_in;
         still_r_ff[0] <= still_q_ff[QD];
         dovf_r_ff[0]  <= dovf_q_ff[QD] && !still_q_ff[QD];
         for (int j = 0; j < RW; j++) begin
            ra_rem_ff[j+1]  <= ra_rem_in[j+1];
            ra_ff[j+1]      <= ra_in[j+1];
            rb_rem_ff[j+1]  <= rb_rem_in[j+1];
            rb_ff[j+1]      <= rb_in[j+1];
            tres_ff[j+1]    <= tres_ff[j];
            tsat_ff[j+1]    <= tsat_ff[j];
            still_r_ff[j+1] <= still_r_ff[j];
            dovf_r_ff[j+1]  <= dovf_r_ff[j];
         end
         time_ff  <= tres_ff[RW];
         dist_ff  <= dist_in;
         speed_ff <= speed_in;
         still_ff <= still_r_ff[RW];
         sat_ff   <= tsat_ff[RW] || dsat || ssat;
      end
   end

   // response beat
   assign rsp_tdata = {speed_ff, dist_ff, time_ff};
   always_comb begin
      rsp_tuser = '0;
      rsp_tuser[cpa3d_pkg::USER_STILL_BIT] = still_ff;
      rsp_tuser[cpa3d_pkg::USER_SAT_BIT]   = sat_ff;
   end

   // no relative motion means zero time and zero closing speed
   a_still_time_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && still_ff |-> time_ff == '0)
      else $error("time not zero without relative motion");

   // without relative motion nothing can clip
   a_still_speed_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && still_ff |-> speed_ff == '0 && !sat_ff)
      else $error("speed not zero without relative motion");

   // reset empties every stage
   a_reset_flush: assert property (@(posedge clock)
      $past(reset) |-> vld_ff == '0)
      else $error("pipeline not empty after reset");

   // a divide overflow on the distance path always reaches the response as saturation
   a_dist_ovf_sat: assert property (@(posedge clock) disable iff (reset)
      vld_ff[NSTG-2] && dovf_r_ff[RW] && adv |=> sat_ff && dist_ff == LMAX)
      else $error("distance overflow not saturated");

endmodule

`default_nettype wire

// File: dv/closest_approach_3d_unit_test.sv
`timescale 1ns / 1ps

module closest_approach_3d_unit_test;

   localparam int NUM_IN_FIELDS  = cpa3d_pkg::NUM_IN_FIELDS;
   localparam int COORD_WIDTH    = cpa3d_pkg::COORD_WIDTH;
   localparam int FRAC_BITS      = cpa3d_pkg::FRAC_BITS;
   localparam int TIME_WIDTH     = cpa3d_pkg::TIME_WIDTH;
   localparam int LEN_WIDTH      = cpa3d_pkg::LEN_WIDTH;
   localparam int RSP_DATA_W     = cpa3d_pkg::RSP_DATA_W;
   localparam int RSP_USER_W     = cpa3d_pkg::RSP_USER_W;
   localparam int USER_STILL_BIT = cpa3d_pkg::USER_STILL_BIT;
   localparam int USER_SAT_BIT   = cpa3d_pkg::USER_SAT_BIT;

   localparam int REQ_W = NUM_IN_FIELDS * COORD_WIDTH;
   localparam int LATENCY = 117;

   typedef struct packed {
      logic                  sat;
      logic                  still;
      logic [LEN_WIDTH-1:0]  speed;
      logic [LEN_WIDTH-1:0]  distance;
      logic [TIME_WIDTH-1:0] tval;
   } cpa_result_type;

   // scoreboard: computes expected closest approach and checks response beats
   class cpa_scoreboard_type;
      cpa_result_type pending[$];
      int fails;
      int checked;

      function logic [255:0] isqrt(logic [255:0] x);
         logic [255:0] r, c;
         r = '0;
         for (int b = 127; b >= 0; b--) begin
            c = r | (256'd1 << b);
            if (c * c <= x) r = c;
         end
         return r;
      endfunction

      function logic [LEN_WIDTH-1:0] clip_len(logic [255:0] v, ref logic sat);
         if (v > {LEN_WIDTH{1'b1}}) begin
            sat = 1'b1;
            return {LEN_WIDTH{1'b1}};
         end
         return v[LEN_WIDTH-1:0];
      endfunction

      function void note_request(logic [REQ_W-1:0] d);
         logic signed [255:0] dr[3], dv[3], cx[3];
         logic signed [255:0] vv, pp, dd, cc, mag, q;
         logic signed [255:0] tmax;
         cpa_result_type e;
         logic sat;
         sat = 1'b0;
         for (int i = 0; i < 3; i++) begin
            dr[i] = $signed(d[i*32 +: 32]) - $signed(d[(6+i)*32 +: 32]);
            dv[i] = $signed(d[(3+i)*32 +: 32]) - $signed(d[(9+i)*32 +: 32]);
         end
         vv = 0; pp = 0; dd = 0; cc = 0;
         for (int i = 0; i < 3; i++) begin
            vv += dv[i] * dv[i];
            pp += dr[i] * dv[i];
            dd += dr[i] * dr[i];
         end
         cx[0] = dr[1] * dv[2] - dr[2] * dv[1];
         cx[1] = dr[2] * dv[0] - dr[0] * dv[2];
         cx[2] = dr[0] * dv[1] - dr[1] * dv[0];
         for (int i = 0; i < 3; i++) cc += cx[i] * cx[i];
         e.still = (vv == 0);
         e.speed = clip_len(isqrt(vv), sat);
         e.tval = '0;
         if (e.still) begin
            e.distance = clip_len(isqrt(dd), sat);
         end else begin
            mag = (pp < 0) ? -pp : pp;
            q = (mag <<< FRAC_BITS) / vv;
            tmax = (256'sd1 <<< (TIME_WIDTH - 1)) - 1;
            if (pp < 0) begin
               if (q > tmax) begin sat = 1'b1; q = tmax; end
               e.tval = q[TIME_WIDTH-1:0];
            end else begin
               if (q > tmax + 1) begin sat = 1'b1; q = tmax + 1; end
               e.tval = -q[TIME_WIDTH-1:0];
            end
            e.distance = clip_len(isqrt(cc / vv), sat);
         end
         e.sat = sat;
         pending.push_back(e);
      endfunction

      function void check_response(logic [RSP_DATA_W-1:0] d, logic [RSP_USER_W-1:0] u);
         cpa_result_type a, e;
         a = {u[USER_SAT_BIT], u[USER_STILL_BIT], d};
         checked++;
         if (pending.size() == 0) begin
            $display("%0t: unexpected beat %h", $time, a);
            fails++;
            return;
         end
         e = pending.pop_front();
         if (a.tval !== e.tval) begin
            $display("%0t: time exp %h got %h", $time, e.tval, a.tval); fails++;
         end
         if (a.distance !== e.distance) begin
            $display("%0t: distance exp %h got %h", $time, e.distance, a.distance); fails++;
         end
         if (a.speed !== e.speed) begin
            $display("%0t: speed exp %h got %h", $time, e.speed, a.speed); fails++;
         end
         if (a.still !== e.still) begin
            $display("%0t: still exp %b got %b", $time, e.still, a.still); fails++;
         end
         if (a.sat !== e.sat) begin
            $display("%0t: sat exp %b got %b", $time, e.sat, a.sat); fails++;
         end
      endfunction
   endclass

   logic clock, reset;
   logic req_tvalid, req_tready, rsp_tvalid, rsp_tready;
   logic [REQ_W-1:0] req_tdata;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic [RSP_USER_W-1:0] rsp_tuser;
   logic calm;
   int sent;
   cpa_scoreboard_type sb;

   closest_approach_3d_unit u_top (.*);

   initial begin
      clock = 0;
      forever #5 clock = ~clock;
   end

   initial begin
      #50ms;
      $display("status: fail");
      $finish;
   end

   // one coordinate: extremes, small values or full random
   function logic [31:0] pick_coord();
      case ($urandom_range(0, 9))
         0: return 32'h8000_0000;
         1: return 32'h7fff_ffff;
         2: return 32'h0;
         3, 4, 5: return $urandom_range(0, 8191) - 4096;
         6: return $urandom_range(0, 1) ? 32'hffff_ffff : 32'h1;
         default: return $urandom;
      endcase
   endfunction

   function logic [REQ_W-1:0] pick_item();
      logic [REQ_W-1:0] d;
      int mode;
      mode = $urandom_range(0, 5);
      for (int i = 0; i < NUM_IN_FIELDS; i++) d[i*32 +: 32] = pick_coord();
      // equal velocities give no relative motion
      if (mode == 0) d[9*32 +: 96] = d[3*32 +: 96];
      // equal positions: zero relative position, so zero distance
      if (mode == 1) d[6*32 +: 96] = d[0*32 +: 96];
      return d;
   endfunction

   // valid drops only while idling, so one beat leads straight into the next
   task automatic send(logic [REQ_W-1:0] d);
      while (!calm && $urandom_range(0, 99) < 38) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= d;
      do @(posedge clock); while (!req_tready);
      sb.note_request(d);
      sent++;
   endtask

   // response side back-pressure
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) sb.check_response(rsp_tdata, rsp_tuser);
         rsp_tready <= calm || ($urandom_range(0, 99) >= 38);
      end
   end

   initial begin
      logic [REQ_W-1:0] d;
      int waited;
      sb = new();
      reset = 1; req_tvalid = 0; req_tdata = '0; calm = 0; sent = 0;
      repeat (7) @(posedge clock);
      reset <= 0;
      @(posedge clock);
      // directed: zeros, extremes, no motion, negative time
      send('0);
      send({NUM_IN_FIELDS{32'h7fff_ffff}});
      send({NUM_IN_FIELDS{32'h8000_0000}});
      d = '0; d[3*32 +: 32] = 32'h7fff_ffff; d[9*32 +: 32] = 32'h8000_0000;
      d[6*32 +: 32] = 32'h8000_0000; send(d);
      d = '0; d[0] = 1; d[3*32 +: 32] = 32'h8000_0000; d[9*32 +: 32] = 32'h7fff_ffff;
      send(d);
      d = '0; d[0*32 +: 32] = 32'h0001_0000; d[3*32 +: 32] = 32'h0001_0000; send(d);
      d = '0; d[0*32 +: 32] = 32'hffff_0000; d[3*32 +: 32] = 32'h0001_0000; send(d);
      d = '0; d[1*32 +: 32] = 32'h0005_0000; d[3*32 +: 32] = 32'h0000_0001; send(d);
      d = '0; d[0*32 +: 96] = {3{32'h8000_0000}}; d[6*32 +: 96] = {3{32'h7fff_ffff}};
      send(d);
      for (int i = 0; i < NUM_IN_FIELDS; i++) begin
         d = '0; d[i*32 +: 32] = 32'hffff_ffff; send(d);
      end
      // random, with a stretch of no idling in the middle
      for (int n = 0; n < 850; n++) begin
         calm <= (n >= 300 && n < 420);
         send(pick_item());
      end
      req_tvalid <= 1'b0;
      calm <= 0;
      waited = 0;
      while (sb.pending.size() != 0 && waited < 100000) begin
         @(posedge clock); waited++;
      end
      repeat (LATENCY + 20) @(posedge clock);
      $display("sent %0d vector pairs, checked %0d responses incl. extremes and still cases",
               sent, sb.checked);
      if (sb.fails == 0 && sb.pending.size() == 0) $display("status: pass");
      else $display("status: fail");
      $finish;
   end
endmodule
